// ===== hw/rtl/arp_pkg.sv =====
package arp_pkg;

  localparam int TABLE_ENTRIES = 256;
  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CNT_W-1:0] CAPACITY = CNT_W'(TABLE_ENTRIES - 1);

  localparam logic [15:0] ETYPE_IP = 16'h0800;
  localparam logic [15:0] ETYPE_ARP = 16'h0806;
  localparam logic [15:0] HW_ETHERNET = 16'h0001;
  localparam logic [15:0] OPER_REQUEST = 16'h0001;
  localparam logic [47:0] BCAST_MAC = 48'hFFFF_FFFF_FFFF;

  localparam int ADDR_W = 4;
  localparam logic [ADDR_W-1:0] REG_OWN_MAC = 4'h0;
  localparam logic [ADDR_W-1:0] REG_OWN_IP = 4'h8;

  typedef enum logic [2:0] {
    ACT_NONE = 3'd0,
    ACT_IP = 3'd1,
    ACT_ARP_REQ = 3'd2,
    ACT_ARP_REPLY = 3'd3,
    ACT_UP = 3'd4
  } action_t;

  // classification done by the front end
  typedef enum logic [1:0] {
    K_SEND = 2'd0,
    K_IPRX = 2'd1,
    K_ARP = 2'd2,
    K_OTHER = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t kind;
    logic to_us;       // IP: dest mac ours; ARP: target ip ours
    logic is_request;
    logic [47:0] sender_mac;
    logic [31:0] sender_ip;
    logic [31:0] target_ip;
  } job_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_WAIT,
    S_CHECK,
    S_UPDATE,
    S_EMIT
  } state_t;

endpackage

// ===== hw/rtl/arp_if.sv =====
interface arp_in_if;
  logic valid;
  logic ready;
  logic opcode;
  logic [47:0] frame_dest_mac;
  logic [15:0] ether_type;
  logic [15:0] hw_type;
  logic [15:0] proto_type;
  logic [15:0] arp_oper;
  logic [47:0] sender_mac;
  logic [31:0] sender_ip;
  logic [31:0] target_ip;
  modport source(output valid, opcode, frame_dest_mac, ether_type, hw_type, proto_type,
    arp_oper, sender_mac, sender_ip, target_ip, input ready);
  modport sink(input valid, opcode, frame_dest_mac, ether_type, hw_type, proto_type,
    arp_oper, sender_mac, sender_ip, target_ip, output ready);
endinterface

interface arp_out_if;
  logic valid;
  logic ready;
  logic [2:0] action;
  logic [47:0] out_dest_mac;
  logic [47:0] out_target_mac;
  logic [31:0] out_target_ip;
  logic add_dropped;
  modport source(output valid, action, out_dest_mac, out_target_mac, out_target_ip,
    add_dropped, input ready);
  modport sink(input valid, action, out_dest_mac, out_target_mac, out_target_ip,
    add_dropped, output ready);
endinterface

// ===== hw/rtl/arp_ram.sv =====
module arp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== hw/rtl/arp_front.sv =====
module arp_front (
  input  logic          clk,
  input  logic          rst,
  arp_in_if.sink        in_ch,
  input  logic [47:0]   own_mac,
  input  logic [31:0]   own_ip,
  output arp_pkg::job_t job,
  output logic          job_valid,
  input  logic          job_pop
);
  import arp_pkg::*;

  // two-entry queue toward the back end
  job_t q [2];
  logic rd_ptr, wr_ptr;
  logic [1:0] fill;
  job_t cls;
  logic push;

  always_comb begin
    cls.sender_mac = in_ch.sender_mac;
    cls.sender_ip = in_ch.sender_ip;
    cls.target_ip = in_ch.target_ip;
    cls.is_request = in_ch.arp_oper == OPER_REQUEST;
    cls.to_us = 1'b0;
    if (in_ch.opcode == 1'b0) begin
      cls.kind = K_SEND;
    end else if (in_ch.ether_type == ETYPE_IP) begin
      cls.kind = K_IPRX;
      cls.to_us = in_ch.frame_dest_mac == own_mac;
    end else if (in_ch.ether_type == ETYPE_ARP && in_ch.hw_type == HW_ETHERNET &&
                 in_ch.proto_type == ETYPE_IP) begin
      cls.kind = K_ARP;
      cls.to_us = in_ch.target_ip == own_ip;
    end else begin
      cls.kind = K_OTHER;
    end
  end

  assign in_ch.ready = fill != 2'd2;
  assign push = in_ch.valid && in_ch.ready;
  assign job = q[rd_ptr];
  assign job_valid = fill != 2'd0;

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= cls;
    end
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (job_pop) rd_ptr <= ~rd_ptr;
      fill <= fill + 2'(push) - 2'(job_pop);
    end
  end
endmodule

// ===== hw/rtl/arp_back.sv =====
module arp_back (
  input  logic          clk,
  input  logic          rst,
  input  arp_pkg::job_t job,
  input  logic          job_valid,
  output logic          job_pop,
  arp_out_if.source     out_ch
);
  import arp_pkg::*;

  state_t state, state_next;
  job_t cur;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] scan;
  logic [CNT_W-1:0] scan_inc;
  logic scan_hit;
  logic found;
  logic [IDX_W-1:0] hit_idx;
  logic [31:0] key;
  logic [31:0] ip_rd;
  logic [47:0] mac_rd;
  logic [IDX_W-1:0] raddr;
  logic ip_we, mac_we;
  logic [IDX_W-1:0] mac_waddr;
  logic do_add;
  logic [2:0] act_r;
  logic [47:0] dmac_r, tmac_r;
  logic [31:0] tip_r;
  logic drop_r;

  arp_ram #(.WIDTH(32), .DEPTH(TABLE_ENTRIES)) u_ip (
    .clk(clk), .we(ip_we), .waddr(count[IDX_W-1:0]), .wdata(cur.sender_ip),
    .raddr(raddr), .rdata(ip_rd));
  arp_ram #(.WIDTH(48), .DEPTH(TABLE_ENTRIES)) u_mac (
    .clk(clk), .we(mac_we), .waddr(mac_waddr), .wdata(cur.sender_mac),
    .raddr(raddr), .rdata(mac_rd));

  assign key = (cur.kind == K_SEND) ? cur.target_ip : cur.sender_ip;
  assign raddr = (state == S_CHECK) ? hit_idx : scan[IDX_W-1:0];
  assign do_add = cur.kind == K_ARP && cur.to_us && !found && count < CAPACITY;
  assign scan_hit = ip_rd == key;
  assign scan_inc = scan + 1'b1;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (job_valid) state_next = S_SEARCH;
      S_SEARCH: state_next = (scan < count) ? S_WAIT : S_UPDATE;
      S_WAIT: state_next = S_CHECK;
      // stop on a hit or once the last filled entry has been compared
      S_CHECK: state_next = (scan_hit || !(scan_inc < count)) ? S_UPDATE : S_WAIT;
      S_UPDATE: state_next = S_EMIT;
      S_EMIT: if (out_ch.ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    job_pop = state == S_IDLE && job_valid;
    ip_we = state == S_UPDATE && do_add;
    mac_we = state == S_UPDATE && cur.kind == K_ARP && (found || do_add);
    mac_waddr = found ? hit_idx : count[IDX_W-1:0];
    out_ch.valid = state == S_EMIT;
    out_ch.action = act_r;
    out_ch.out_dest_mac = dmac_r;
    out_ch.out_target_mac = tmac_r;
    out_ch.out_target_ip = tip_r;
    out_ch.add_dropped = drop_r;
  end

  // S_WAIT: read issued at scan; S_CHECK compares ip_rd and advances
  always_ff @(posedge clk) begin
    if (job_pop) begin
      cur <= job;
    end
    unique case (state)
      S_IDLE: begin
        scan <= '0;
        found <= 1'b0;
      end
      S_WAIT: hit_idx <= scan[IDX_W-1:0];
      S_CHECK: begin
        found <= scan_hit;
        if (!scan_hit) scan <= scan_inc;
      end
      S_UPDATE: begin
        act_r <= ACT_NONE;
        dmac_r <= '0;
        tmac_r <= '0;
        tip_r <= '0;
        drop_r <= cur.kind == K_ARP && cur.to_us && !found && !(count < CAPACITY);
        unique case (cur.kind)
          K_SEND: begin
            if (found) begin
              act_r <= ACT_IP;
              dmac_r <= mac_rd;
            end else begin
              act_r <= ACT_ARP_REQ;
              dmac_r <= BCAST_MAC;
              tmac_r <= BCAST_MAC;
              tip_r <= cur.target_ip;
            end
          end
          K_IPRX: if (cur.to_us) act_r <= ACT_UP;
          K_ARP: begin
            if (cur.to_us && cur.is_request) begin
              act_r <= ACT_ARP_REPLY;
              dmac_r <= cur.sender_mac;
              tmac_r <= cur.sender_mac;
              tip_r <= cur.sender_ip;
            end
          end
          K_OTHER: ;
          default: ;
        endcase
      end
      default: ;
    endcase
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (ip_we) count <= count + 1'b1;
    end
  end
endmodule

// ===== hw/rtl/arp_resolver_table.sv =====
// ARP resolver with a 256-deep IPv4-to-MAC table that holds at most 255 entries.
// Per item the back end steps S_IDLE, S_SEARCH, an S_WAIT/S_CHECK pair per entry compared
// (through the hit, else the fill count), S_UPDATE and S_EMIT; the search reads one RAM entry per pair.
// The back end handles one item at a time; a two-entry queue lets input run ahead.
// Reset: synchronous, clears the fill count, queue pointers, FSM state and own MAC/IP registers; table contents stay.
module arp_resolver_table (
  input  logic        clk,
  input  logic        rst,
  arp_in_if.sink      in_ch,
  arp_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [arp_pkg::ADDR_W-1:0] paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import arp_pkg::*;

  logic [47:0] own_mac;
  logic [31:0] own_ip;
  job_t job;
  logic job_valid, job_pop;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_mac <= '0;
      own_ip <= '0;
    end else if (psel && penable && pwrite) begin
      if (paddr == REG_OWN_MAC) own_mac <= pwdata[47:0];
      else if (paddr == REG_OWN_IP) own_ip <= pwdata[31:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == REG_OWN_MAC) prdata = {16'h0, own_mac};
    else if (paddr == REG_OWN_IP) prdata = {32'h0, own_ip};
  end

  arp_front u_front (
    .clk(clk), .rst(rst), .in_ch(in_ch), .own_mac(own_mac), .own_ip(own_ip),
    .job(job), .job_valid(job_valid), .job_pop(job_pop));

  arp_back u_back (
    .clk(clk), .rst(rst), .job(job), .job_valid(job_valid), .job_pop(job_pop),
    .out_ch(out_ch));
endmodule
